@@ rtl/dssm_pkg.sv @@
// Package for the drum sample sequencer mixer: sizes, operation codes,
// the command struct broadcast to the voice cells and small helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dssm_pkg;

    localparam int NUM_VOICES         = 11;
    localparam int NUM_STEPS          = 8;
    localparam int VOICE_SAMPLE_DEPTH = 131072;

    localparam int TICKS_PER_KNOB = 480;
    localparam int GAIN_DIVISOR   = 100;

    localparam int SAMPLE_ADDR_W = $clog2(VOICE_SAMPLE_DEPTH);
    localparam int BEAT_W        = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;
    localparam int VOICE_IDX_W   = 4;
    localparam int POS_W         = 17;
    localparam int PERIOD_W      = 17;
    localparam int TERM_W        = 19;
    localparam int MIX_W         = 16 + 2 + $clog2(NUM_VOICES + 1) + 1;
    localparam int FACTOR_W      = 11;
    localparam int PROD_W        = 16 + FACTOR_W;
    localparam int CNT_W         = $clog2(NUM_VOICES + 1);

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_LENGTH = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    // Broadcast from the sequencer to every voice cell
    typedef struct packed {
        logic                   tick;      // tick transfer, gain update
        logic                   play;      // tick without wrap: fetch sample
        logic                   load;      // latch fetched sample into last value
        logic                   wr;
        logic                   set_len;
        logic                   toggle;
        logic                   clear;
        logic [VOICE_IDX_W-1:0] voice;
        logic [2:0]             step;
        logic [16:0]            addr;
        logic signed [15:0]     word;
        logic [16:0]            len;
        logic [1:0]             gain;
    } cell_cmd_t;

    function automatic logic [1:0] gain_code(input logic [7:0] knob);
        if (knob >= 8'(2 * GAIN_DIVISOR))
            return 2'd3;
        else if (knob >= 8'(GAIN_DIVISOR))
            return 2'd2;
        else
            return 2'd1;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [MIX_W-1:0] v);
        if (v > MIX_W'(32767))
            return 16'sh7fff;
        else if (v < -MIX_W'(32768))
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/dssm_voice_cell.sv @@
// One voice of the drum machine: sample memory, length, pattern, gain and
// last value, plus one adder stage of the mix chain. Uses dssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssm_voice_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [dssm_pkg::VOICE_IDX_W-1:0]    cell_id,
    input  wire dssm_pkg::cell_cmd_t                 cmd,
    input  wire logic [dssm_pkg::POS_W-1:0]          pos,
    input  wire logic [dssm_pkg::BEAT_W-1:0]         beat,
    input  wire logic signed [dssm_pkg::MIX_W-1:0]   sum_in,
    output logic signed [dssm_pkg::MIX_W-1:0]        sum_out
);
    import dssm_pkg::*;

    logic signed [15:0]       mem [VOICE_SAMPLE_DEPTH];
    logic signed [15:0]       rd_reg;
    logic                     play_reg;
    logic [16:0]              len_reg;
    logic [NUM_STEPS-1:0]     pattern_reg;
    logic [1:0]               gain_reg;
    logic signed [15:0]       last_reg;
    logic signed [MIX_W-1:0]  sum_reg;
    logic                     sel;
    logic                     addr_ok;
    logic signed [TERM_W-1:0] term;

    assign sel     = (cmd.voice == cell_id);
    assign addr_ok = 32'(cmd.addr) < VOICE_SAMPLE_DEPTH;
    assign term    = last_reg * $signed({1'b0, gain_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.wr && sel && addr_ok)
            mem[SAMPLE_ADDR_W'(cmd.addr)] <= cmd.word;
        if (cmd.play)
            rd_reg <= mem[SAMPLE_ADDR_W'(pos)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg    <= 1'b0;
            len_reg     <= '0;
            pattern_reg <= '0;
            gain_reg    <= 2'd1;
            last_reg    <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (cmd.play)
                play_reg <= pattern_reg[beat] && (32'(pos) < 32'(len_reg))
                            && (32'(pos) < VOICE_SAMPLE_DEPTH);
            if (cmd.tick && sel)
                gain_reg <= cmd.gain;
            if (cmd.set_len && sel)
                len_reg <= cmd.len;
            if (cmd.clear)
                pattern_reg <= '0;
            else if (cmd.toggle && sel && (32'(cmd.step) < NUM_STEPS))
                pattern_reg[BEAT_W'(cmd.step)] <= ~pattern_reg[BEAT_W'(cmd.step)];
            if (cmd.load)
                last_reg <= play_reg ? rd_reg : 16'sd0;
            // hand the running mix to the next cell every cycle
            sum_reg <= sum_in + MIX_W'(term);
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

@@ rtl/dssm_master_scale.sv @@
// Master stage: saturate the mix, scale by master_knob*4-1, shift by 14.
// Uses dssm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dssm_master_scale (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic signed [dssm_pkg::MIX_W-1:0]  mix,
    input  wire logic [7:0]                         master_knob,
    output logic signed [15:0]                      audio
);
    import dssm_pkg::*;

    logic signed [FACTOR_W-1:0] factor;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   shifted;

    assign factor = $signed({1'b0, master_knob, 2'b00}) - FACTOR_W'(1);

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= sat16(mix) * factor;
    end

    // |factor| < 2^10, so the shifted product always fits 16 bits
    assign shifted = prod_reg >>> 14;
    assign audio   = shifted[15:0];

endmodule

`default_nettype wire

@@ rtl/drum_sample_sequencer_mixer_core.sv @@
// Top level of the drum sample sequencer mixer: stream ports, sequencer,
// chain of voice cells and master scaling. Uses dssm_pkg, dssm_voice_cell,
// dssm_master_scale.
//
// Channel  Dir  tdata                                   tuser
// s_*      in   voice..tempo_knob packed, 88 bits       operation
// m_*      out  mix_sample, current_beat, 24 bits       audio_valid
//
// A tick result passes these steps: the transfer edge fetches the samples,
// ST_LOAD loads them into the last values, ST_ACCUM lets the mix ripple
// through the chain of voice cells, ST_SCALE multiplies, ST_OUT loads the
// output. The next transfer is taken in ST_IDLE after that. Other operations
// go from the transfer straight to ST_OUT, which loads their result. rst_n
// clears all control state, patterns, lengths and gains (to 1); sample memory
// is not cleared. The result waits in the output register while the next item
// is taken; a new result waits in ST_OUT for the register to drain, which
// stalls the input meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module drum_sample_sequencer_mixer_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // voice[3:0] step_index[6:4] sample_address[23:7] sample_word[39:24]
    // length_value[56:40] gain_knob[64:57] master_knob[72:65]
    // tempo_knob[80:73], zero [87:81]
    input  wire logic [dssm_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation[2:0]
    input  wire logic [2:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // mix_sample[15:0] current_beat[18:16], zero [23:19]
    output logic [dssm_pkg::OUT_DATA_W-1:0]       m_tdata,
    // audio_valid[0]
    output logic [0:0]                            m_tuser
);
    import dssm_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_ACCUM = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [BEAT_W-1:0]       beat_reg;
    logic                    tick_reg;
    logic [7:0]              mknob_reg;
    logic                    m_valid_reg;
    logic [15:0]             m_audio_reg;
    logic [2:0]              m_beat_reg;
    logic                    m_flag_reg;
    logic                    in_acc;
    logic                    is_tick;
    logic                    wrap;
    logic [PERIOD_W-1:0]     period;
    logic                    out_free;
    logic signed [15:0]      audio;
    cell_cmd_t               cmd;
    logic signed [MIX_W-1:0] chain [NUM_VOICES+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == OP_TICK);
    assign period   = PERIOD_W'(s_tdata[80:73]) * PERIOD_W'(TICKS_PER_KNOB);
    assign wrap     = pos_reg > period;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        cmd         = '0;
        cmd.tick    = in_acc && is_tick;
        cmd.play    = in_acc && is_tick && !wrap;
        cmd.load    = (state_reg == ST_LOAD);
        cmd.wr      = in_acc && (s_tuser == OP_WRITE);
        cmd.set_len = in_acc && (s_tuser == OP_LENGTH);
        cmd.toggle  = in_acc && (s_tuser == OP_TOGGLE);
        cmd.clear   = in_acc && (s_tuser == OP_CLEAR);
        cmd.voice   = s_tdata[3:0];
        cmd.step    = s_tdata[6:4];
        cmd.addr    = s_tdata[23:7];
        cmd.word    = s_tdata[39:24];
        cmd.len     = s_tdata[56:40];
        cmd.gain    = gain_code(s_tdata[64:57]);
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < NUM_VOICES; i++)
    begin : g_cell
        dssm_voice_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (VOICE_IDX_W'(i)),
            .cmd     (cmd),
            .pos     (pos_reg),
            .beat    (beat_reg),
            .sum_in  (chain[i]),
            .sum_out (chain[i+1])
        );
    end

    dssm_master_scale u_master (
        .clk         (clk),
        .en          (state_reg == ST_SCALE),
        .mix         (chain[NUM_VOICES]),
        .master_knob (mknob_reg),
        .audio       (audio)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = is_tick ? ST_LOAD : ST_OUT;
            end
            ST_LOAD:  state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (cnt_reg == CNT_W'(NUM_VOICES - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WAIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            pos_reg     <= '0;
            beat_reg    <= '0;
            tick_reg    <= 1'b0;
            mknob_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_audio_reg <= '0;
            m_beat_reg  <= '0;
            m_flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                tick_reg  <= is_tick;
                mknob_reg <= s_tdata[72:65];
                if (is_tick)
                begin
                    if (wrap)
                    begin
                        pos_reg  <= '0;
                        beat_reg <= (32'(beat_reg) == NUM_STEPS - 1)
                                    ? '0 : beat_reg + 1'b1;
                    end
                    else
                        pos_reg <= pos_reg + 1'b1;
                end
            end
            if (state_reg == ST_ACCUM)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
            if (state_reg == ST_OUT && out_free)
            begin
                m_valid_reg <= 1'b1;
                m_flag_reg  <= tick_reg;
                m_audio_reg <= tick_reg ? audio : 16'd0;
                m_beat_reg  <= 3'(beat_reg);
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_beat_reg, m_audio_reg};
    assign m_tuser  = m_flag_reg;

    // beat moves only on a tick transfer
    a_beat_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(beat_reg))
        else $error("beat index changed without a transfer");

    a_wrap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && is_tick && wrap |=> pos_reg == '0)
        else $error("position counter not cleared on wrap");

    a_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("non-tick result carries audio");

    a_nontick_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !is_tick |=> state_reg == ST_OUT)
        else $error("non-tick item entered the mix path");

endmodule

`default_nettype wire
